// ===== src/lelr_pkg.sv =====
// Shared constants for the line-evicting log ring.
`timescale 1ns / 1ps

package lelr_pkg;

    localparam int SYM_W   = 8;
    localparam int IDX_W   = 10;
    localparam int WPOS_W  = 10;
    localparam int EVCNT_W = 11;

    localparam logic [SYM_W-1:0] LINE_END   = 8'h0A;
    localparam logic [SYM_W-1:0] EMPTY_SLOT = 8'h00;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

// ===== src/line_evicting_log_ring_top.sv =====
// Top level of the line-evicting log ring: sequencer, store and result register.
// A read passes the read-data and done states; an append clears slots from the write pointer
// until it clears a line end or the whole store, unless that slot is empty, then passes the
// store and done states. The next word is taken once the result is in the output register, so
// the block holds one word at a time and waits while the output stalls. After reset, taking no
// word, a sweep puts a line end in slot zero, clears the rest and leaves the write pointer at one.
`timescale 1ns / 1ps

module line_evicting_log_ring_top #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [lelr_pkg::SYM_W-1:0]    symbol,
    input  logic [lelr_pkg::IDX_W-1:0]    read_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lelr_pkg::SYM_W-1:0]    read_data,
    output logic [lelr_pkg::EVCNT_W-1:0]  evicted_count,
    output logic [lelr_pkg::WPOS_W-1:0]   write_position
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RDATA = 6'b000100,
        ST_EVICT = 6'b001000,
        ST_STORE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                wp_reg, wp_next;
    logic [AW-1:0]                walk_pos_reg, walk_pos_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         first_reg, first_next;
    logic [lelr_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic                         idx_ok_reg, idx_ok_next;
    logic [lelr_pkg::SYM_W-1:0]   res_data_reg, res_data_next;
    logic                         out_valid_reg, out_valid_next;
    logic [lelr_pkg::SYM_W-1:0]   read_data_reg, read_data_next;
    logic [lelr_pkg::EVCNT_W-1:0] evicted_reg, evicted_next;
    logic [lelr_pkg::WPOS_W-1:0]  wpos_reg, wpos_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [lelr_pkg::SYM_W-1:0]   ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [lelr_pkg::SYM_W-1:0]   ram_rdata;

    logic [AW-1:0]                unit_pos;
    logic [AW-1:0]                unit_pos_next;
    logic                         unit_wrap;
    logic [CW-1:0]                unit_cnt_inc;
    logic                         unit_cnt_full;

    logic [31:0]                  idx_ext;
    logic [31:0]                  wp_ext;
    logic [31:0]                  count_ext;

    lelr_ram #(
        .WIDTH (lelr_pkg::SYM_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lelr_walk_unit #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_walk (
        .pos      (unit_pos),
        .cnt      (count_reg),
        .pos_next (unit_pos_next),
        .wrap     (unit_wrap),
        .cnt_inc  (unit_cnt_inc),
        .cnt_full (unit_cnt_full)
    );

    assign idx_ext   = 32'(read_index);
    assign wp_ext    = 32'(wp_reg);
    assign count_ext = 32'(count_reg);

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign evicted_count  = evicted_reg;
    assign write_position = wpos_reg;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        walk_pos_next  = walk_pos_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        sym_next       = sym_reg;
        idx_ok_next    = idx_ok_reg;
        res_data_next  = res_data_reg;
        out_valid_next = out_valid_reg & out_stall;
        read_data_next = read_data_reg;
        evicted_next   = evicted_reg;
        wpos_next      = wpos_reg;
        ram_we         = 1'b0;
        ram_waddr      = walk_pos_reg;
        ram_wdata      = lelr_pkg::EMPTY_SLOT;
        ram_raddr      = walk_pos_reg;
        unit_pos       = walk_pos_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = (walk_pos_reg == '0) ? lelr_pkg::LINE_END : lelr_pkg::EMPTY_SLOT;
                walk_pos_next = unit_pos_next;
                if (unit_wrap)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    count_next = '0;
                    if (operation == lelr_pkg::OP_READ)
                    begin
                        ram_raddr   = idx_ext[AW-1:0];
                        idx_ok_next = (idx_ext < 32'(STORE_DEPTH));
                        state_next  = ST_RDATA;
                    end
                    else
                    begin
                        ram_raddr     = wp_reg;
                        walk_pos_next = wp_reg;
                        first_next    = 1'b1;
                        sym_next      = symbol;
                        state_next    = ST_EVICT;
                    end
                end
            end
            ST_RDATA:
            begin
                res_data_next = idx_ok_reg ? ram_rdata : lelr_pkg::EMPTY_SLOT;
                state_next    = ST_DONE;
            end
            ST_EVICT:
            begin
                if (first_reg && (ram_rdata == lelr_pkg::EMPTY_SLOT))
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = unit_cnt_inc;
                    first_next = 1'b0;
                    if ((ram_rdata == lelr_pkg::LINE_END) || unit_cnt_full)
                    begin
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        walk_pos_next = unit_pos_next;
                        ram_raddr     = unit_pos_next;
                    end
                end
            end
            ST_STORE:
            begin
                unit_pos      = wp_reg;
                ram_we        = 1'b1;
                ram_waddr     = wp_reg;
                ram_wdata     = sym_reg;
                wp_next       = unit_pos_next;
                res_data_next = lelr_pkg::EMPTY_SLOT;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = res_data_reg;
                    evicted_next   = count_ext[lelr_pkg::EVCNT_W-1:0];
                    wpos_next      = wp_ext[lelr_pkg::WPOS_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            wp_reg        <= AW'(1 % STORE_DEPTH);
            walk_pos_reg  <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b0;
            idx_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            walk_pos_reg  <= walk_pos_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            idx_ok_reg    <= idx_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        res_data_reg  <= res_data_next;
        read_data_reg <= read_data_next;
        evicted_reg   <= evicted_next;
        wpos_reg      <= wpos_next;
    end

endmodule

// ===== src/lelr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module lelr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lelr_walk_unit.sv =====
// Shared position advance and slot counter used by the sweep, the eviction walk and the pointer.
`timescale 1ns / 1ps

module lelr_walk_unit #(
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic [AW-1:0] pos,
    input  logic [CW-1:0] cnt,
    output logic [AW-1:0] pos_next,
    output logic          wrap,
    output logic [CW-1:0] cnt_inc,
    output logic          cnt_full
);

    assign wrap     = (pos == AW'(DEPTH - 1));
    assign pos_next = wrap ? '0 : pos + 1'b1;
    assign cnt_inc  = cnt + 1'b1;
    assign cnt_full = (cnt_inc == CW'(DEPTH));

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the line-evicting log ring, with a cycle-free predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH          = 1024;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int RANDOM_WORDS   = 60;

    typedef struct packed {
        logic [lelr_pkg::SYM_W-1:0]   data;
        logic [lelr_pkg::EVCNT_W-1:0] evicted;
        logic [lelr_pkg::WPOS_W-1:0]  wpos;
    } ring_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          operation;
    logic [lelr_pkg::SYM_W-1:0]    symbol;
    logic [lelr_pkg::IDX_W-1:0]    read_index;
    logic                          out_valid;
    logic                          out_stall;
    logic [lelr_pkg::SYM_W-1:0]    read_data;
    logic [lelr_pkg::EVCNT_W-1:0]  evicted_count;
    logic [lelr_pkg::WPOS_W-1:0]   write_position;

    logic [lelr_pkg::SYM_W-1:0]    shadow_store [DEPTH];
    logic [lelr_pkg::WPOS_W-1:0]   shadow_wptr;
    ring_result_t                  expected_results [$];

    int mismatches;
    int words_sent;
    int results_seen;
    int longest_walk;
    int full_store_walks;
    int send_idle_pct;
    int recv_stall_pct;
    int holds_asked;
    int holds_served;
    int quiet_cycles = 0;

    line_evicting_log_ring_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .symbol         (symbol),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .evicted_count  (evicted_count),
        .write_position (write_position)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The store is exactly as deep as the pointer is wide, so positions wrap by themselves.
    function automatic ring_result_t predict_word(input logic op,
                                                  input logic [lelr_pkg::SYM_W-1:0] sym,
                                                  input logic [lelr_pkg::IDX_W-1:0] idx);
        ring_result_t                r;
        int                          walked;
        logic [lelr_pkg::WPOS_W-1:0] pos;
        logic [lelr_pkg::SYM_W-1:0]  old;
        logic                        hit_end;
        r = '0;
        walked = 0;
        if (op == lelr_pkg::OP_READ)
        begin
            r.data = shadow_store[idx];
        end
        else
        begin
            if (shadow_store[shadow_wptr] != lelr_pkg::EMPTY_SLOT)
            begin
                pos = shadow_wptr;
                hit_end = 1'b0;
                while (walked < DEPTH && !hit_end)
                begin
                    old = shadow_store[pos];
                    shadow_store[pos] = lelr_pkg::EMPTY_SLOT;
                    walked++;
                    pos = pos + 1'b1;
                    hit_end = (old == lelr_pkg::LINE_END);
                end
            end
            shadow_store[shadow_wptr] = sym;
            shadow_wptr = shadow_wptr + 1'b1;
            r.evicted = walked[lelr_pkg::EVCNT_W-1:0];
            if (walked > longest_walk)
                longest_walk = walked;
            if (walked == DEPTH)
                full_store_walks++;
        end
        r.wpos = shadow_wptr;
        return r;
    endfunction

    function automatic logic [lelr_pkg::SYM_W-1:0] text_byte();
        int b;
        b = $urandom_range(254, 1);
        if (b >= lelr_pkg::LINE_END)
            b++;
        return b[lelr_pkg::SYM_W-1:0];
    endfunction

    function automatic logic [lelr_pkg::SYM_W-1:0] rand_byte();
        int b;
        b = $urandom_range(255);
        return b[lelr_pkg::SYM_W-1:0];
    endfunction

    function automatic logic [lelr_pkg::IDX_W-1:0] rand_index();
        int v;
        v = $urandom_range(DEPTH - 1);
        return v[lelr_pkg::IDX_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // The word stays offered, unchanged, until it is taken; the next call decides on a gap.
    task automatic send_word(input logic op, input logic [lelr_pkg::SYM_W-1:0] sym,
                             input logic [lelr_pkg::IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (send_idle_pct != 0)
            while (gap < 60 && $urandom_range(99) < send_idle_pct)
                gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        symbol     <= sym;
        read_index <= idx;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        expected_results.push_back(predict_word(op, sym, idx));
        words_sent++;
    endtask

    task automatic send_line(input int len);
        repeat (len) send_word(lelr_pkg::OP_APPEND, text_byte(), rand_index());
        send_word(lelr_pkg::OP_APPEND, lelr_pkg::LINE_END, rand_index());
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_contents();
        set_idling(0, 0);
        send_word(lelr_pkg::OP_READ, 8'hFF, 10'd0);
        send_word(lelr_pkg::OP_READ, 8'h00, 10'd1);
        send_word(lelr_pkg::OP_READ, 8'hA5, 10'd1023);
        send_word(lelr_pkg::OP_READ, 8'h5A, 10'd512);
    endtask

    task automatic test_append_extremes();
        set_idling(0, 0);
        send_word(lelr_pkg::OP_APPEND, 8'hFF, 10'd1023);
        send_word(lelr_pkg::OP_APPEND, lelr_pkg::EMPTY_SLOT, 10'd0);
        send_word(lelr_pkg::OP_APPEND, lelr_pkg::LINE_END, 10'h155);
        send_word(lelr_pkg::OP_APPEND, 8'h01, 10'h2AA);
        send_word(lelr_pkg::OP_APPEND, 8'h80, 10'h3FF);
        send_word(lelr_pkg::OP_APPEND, 8'h7F, 10'h000);
        send_word(lelr_pkg::OP_READ, 8'h00, 10'd1);
        send_word(lelr_pkg::OP_READ, 8'hFF, 10'd2);
        send_word(lelr_pkg::OP_READ, 8'h55, 10'd3);
        send_word(lelr_pkg::OP_READ, 8'hAA, 10'd4);
        send_word(lelr_pkg::OP_READ, 8'h00, 10'd5);
        send_word(lelr_pkg::OP_READ, 8'h00, 10'd6);
        send_word(lelr_pkg::OP_READ, 8'h00, 10'd7);
        send_word(lelr_pkg::OP_READ, 8'h00, 10'd0);
        wait_drain();
    endtask

    // A full pass of text without a newline, a quarter under each idling mix, leaves nothing
    // to stop a later eviction walk.
    task automatic test_walk_without_newline();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(82, 0);
                2: set_idling(0, 82);
                default: set_idling(11, 11);
            endcase
            repeat (DEPTH / 4) send_word(lelr_pkg::OP_APPEND, text_byte(), rand_index());
        end
        send_word(lelr_pkg::OP_APPEND, text_byte(), rand_index());
        send_word(lelr_pkg::OP_READ, 8'h00, shadow_wptr - 1'b1);
        send_word(lelr_pkg::OP_READ, 8'h00, shadow_wptr);
        send_word(lelr_pkg::OP_READ, 8'h00, rand_index());
        send_line(12);
        send_line(0);
        wait_drain();
    endtask

    task automatic test_output_hold_off();
        set_idling(0, 0);
        holds_asked++;
        repeat (4) send_line($urandom_range(8, 2));
        repeat (8) send_word(lelr_pkg::OP_READ, rand_byte(), rand_index());
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int pick;
        set_idling(11, 11);
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_line($urandom_range(12, 0));
            else if (pick < 70)
                send_word(lelr_pkg::OP_READ, rand_byte(), rand_index());
            else if (pick < 80)
                send_word(lelr_pkg::OP_READ, rand_byte(), shadow_wptr);
            else
                send_word(lelr_pkg::OP_APPEND, rand_byte(), rand_index());
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        operation  <= lelr_pkg::OP_READ;
        symbol     <= '0;
        read_index <= '0;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        longest_walk = 0;
        full_store_walks = 0;
        holds_asked = 0;
        set_idling(0, 0);
        for (int i = 0; i < DEPTH; i++)
            shadow_store[i] = lelr_pkg::EMPTY_SLOT;
        shadow_store[0] = lelr_pkg::LINE_END;
        shadow_wptr = '0;
        shadow_wptr[0] = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_append_extremes();
        test_walk_without_newline();
        test_output_hold_off();
        test_random_traffic();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d words and checked %0d results across four idling phases.",
                 words_sent, results_seen);
        $display("Longest eviction walk %0d slots; %0d walks swept the whole store.",
                 longest_walk, full_store_walks);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        holds_served = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        ring_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result word arrived with nothing expected");
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.data)
                    report_mismatch($sformatf("read_data %0h, expected %0h",
                                              read_data, want.data));
                if (evicted_count !== want.evicted)
                    report_mismatch($sformatf("evicted_count %0d, expected %0d",
                                              evicted_count, want.evicted));
                if (write_position !== want.wpos)
                    report_mismatch($sformatf("write_position %0d, expected %0d",
                                              write_position, want.wpos));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("No word moved for %0d cycles; %0d results still outstanding.",
                     quiet_cycles, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
